// File: rtl/xife_pkg.sv
// Shared types, register indexes and reset values for the XMP frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package xife_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_TIME     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEADER_TIME   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_TIME   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HALFFRAME_GAP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GAP     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER        = 3'd5;

  localparam logic [9:0]  RST_UNIT_TIME     = 10'd137;
  localparam logic [9:0]  RST_LEADER_TIME   = 10'd212;
  localparam logic [11:0] RST_PREFIX_TIME   = 12'd758;
  localparam logic [15:0] RST_HALFFRAME_GAP = 16'd13560;
  localparam logic [16:0] RST_FRAME_GAP     = 17'd82392;
  localparam logic [31:0] RST_HEADER        = 32'h1B0F4458;

  localparam logic [1:0] BLK_HEADER_A = 2'd0;
  localparam logic [1:0] BLK_DATA_A   = 2'd1;
  localparam logic [1:0] BLK_HEADER_B = 2'd2;
  localparam logic [1:0] BLK_DATA_B   = 2'd3;

  localparam logic [3:0] POS_GAP = 4'd8;

  localparam logic [3:0] NIB_BLOCK_START = 4'd1;
  localparam logic [3:0] NIB_B_MARKER    = 4'd8;

  typedef struct packed {
    logic [9:0]  unit_time;
    logic [9:0]  leader_time;
    logic [11:0] nibble_prefix_time;
    logic [15:0] halfframe_gap;
    logic [16:0] frame_gap;
    logic [31:0] header_nibbles;
  } cfg_t;

  typedef struct packed {
    logic [3:0] hi;
    logic [3:0] lo;
    logic [3:0] chk_a;
    logic [3:0] chk_b;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  mark_us;
    logic [16:0] space_us;
    logic        last;
  } pair_t;

endpackage

`default_nettype wire

// File: rtl/xife_front.sv
// Front end: takes key codes, works out the check nibbles and queues frame commands.
`timescale 1ns / 1ps
`default_nettype none

module xife_front
  import xife_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] key_code,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_pop
);

  cmd_t       entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push_fire;
  logic       pop_fire;
  cmd_t       cmd_in;
  logic [3:0] sum_a;

  always_comb begin
    cmd_in.hi    = key_code[7:4];
    cmd_in.lo    = key_code[3:0];
    sum_a        = NIB_BLOCK_START + key_code[7:4] + key_code[3:0];
    cmd_in.chk_a = 4'd0 - sum_a;
    cmd_in.chk_b = 4'd0 - (sum_a + NIB_B_MARKER);
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign push_fire = push && !full;
  assign pop_fire  = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree with count");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && count == 2'd0) |=> (count == 2'd0 || count == 2'd1))
    else $error("command queue underflow");

endmodule

`default_nettype wire

// File: rtl/xife_back.sv
// Back end: steps a frame's 36 pairs, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module xife_back
  import xife_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  wire logic out_space,
  output logic      pair_push,
  output pair_t     pair
);

  logic [1:0]  blk;
  logic [3:0]  pos;
  logic [1:0]  blk_next;
  logic [3:0]  pos_next;
  logic [2:0]  hdr_idx;
  logic [3:0]  nib;
  logic [13:0] scaled;
  logic [14:0] nib_space;
  logic        is_last;
  logic        fire;

  assign hdr_idx = 3'd7 - pos[2:0];
  assign is_last = (blk == BLK_DATA_B) && (pos == POS_GAP);
  assign fire    = cmd_valid && out_space;

  always_comb begin
    nib = 4'd0;
    case (blk)
      BLK_HEADER_A, BLK_HEADER_B: nib = cfg.header_nibbles[{hdr_idx, 2'b00} +: 4];
      BLK_DATA_A, BLK_DATA_B: begin
        case (pos[2:0])
          3'd0:    nib = NIB_BLOCK_START;
          3'd1:    nib = (blk == BLK_DATA_A) ? cmd.chk_a : cmd.chk_b;
          3'd2:    nib = (blk == BLK_DATA_B) ? NIB_B_MARKER : 4'd0;
          3'd4:    nib = cmd.hi;
          3'd5:    nib = cmd.lo;
          default: nib = 4'd0;
        endcase
      end
      default: nib = 4'd0;
    endcase
  end

  assign scaled    = cfg.unit_time * nib;
  assign nib_space = {3'd0, cfg.nibble_prefix_time} + {1'b0, scaled};

  always_comb begin
    pair.mark_us = cfg.leader_time;
    pair.last    = is_last;
    if (pos != POS_GAP) begin
      pair.space_us = {2'd0, nib_space};
    end else begin
      case (blk)
        BLK_DATA_A: pair.space_us = cfg.frame_gap;
        BLK_DATA_B: pair.space_us = 17'd0;
        default:    pair.space_us = {1'b0, cfg.halfframe_gap};
      endcase
    end
  end

  always_comb begin
    blk_next = blk;
    pos_next = pos + 4'd1;
    if (pos == POS_GAP) begin
      pos_next = 4'd0;
      blk_next = blk + 2'd1;
    end
  end

  assign pair_push = fire;
  assign cmd_pop   = fire && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk <= BLK_HEADER_A;
      pos <= 4'd0;
    end else if (fire) begin
      blk <= blk_next;
      pos <= pos_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_GAP)
    else $error("pair position out of range");
  a_pop_wraps: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (blk == BLK_HEADER_A && pos == 4'd0))
    else $error("frame did not restart after its final pair");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(blk) && $stable(pos)))
    else $error("sequencer moved without emitting a pair");

endmodule

`default_nettype wire

// File: rtl/xife_out_fifo.sv
// Two-entry result queue that decouples the sequencer from the result consumer.
`timescale 1ns / 1ps
`default_nettype none

module xife_out_fifo
  import xife_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pair_push,
  input  pair_t     pair_in,
  output logic      out_space,
  output logic      empty,
  input  wire logic pop,
  output pair_t     pair_out
);

  pair_t      entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop_fire;

  assign empty     = (count == 2'd0);
  assign pop_fire  = pop && !empty;
  assign out_space = (count != 2'd2) || pop_fire;
  assign pair_out  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (pair_push) begin
      entries[wr_ptr] <= pair_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (pair_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({pair_push, pop_fire})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop_fire) |-> !pair_push)
    else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

// File: rtl/xmp_ir_frame_encoder.sv
// Top level of the XMP infrared frame encoder: registers, front end, sequencer, result queue.
//
//   Channel   Signals                          Beat
//   input     push, full, key_code             one key code
//   result    empty, pop, mark_us/space_us/last one mark/space pair
//   config    cfg_we, cfg_index, cfg_data      one register write
//
// Each key code yields 36 pairs; the back-end sequencer emits one pair per cycle while a
// command is queued and the result queue has room; a queued frame follows without a gap.
// An accepted key code is registered in the command queue; its pairs pass the result queue.
// Synchronous reset empties both queues, restarts the sequencer and loads register defaults.
// A stalled result side holds the sequencer; the two-entry command queue takes keys until full.
`timescale 1ns / 1ps
`default_nettype none

module xmp_ir_frame_encoder
  import xife_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             key_code,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [9:0]                  mark_us,
  output logic [16:0]                 space_us,
  output logic                        last,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;
  logic  out_space;
  logic  pair_push;
  pair_t pair_gen;
  pair_t pair_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_time          <= RST_UNIT_TIME;
      cfg.leader_time        <= RST_LEADER_TIME;
      cfg.nibble_prefix_time <= RST_PREFIX_TIME;
      cfg.halfframe_gap      <= RST_HALFFRAME_GAP;
      cfg.frame_gap          <= RST_FRAME_GAP;
      cfg.header_nibbles     <= RST_HEADER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_TIME:     cfg.unit_time          <= cfg_data[9:0];
        REG_LEADER_TIME:   cfg.leader_time        <= cfg_data[9:0];
        REG_PREFIX_TIME:   cfg.nibble_prefix_time <= cfg_data[11:0];
        REG_HALFFRAME_GAP: cfg.halfframe_gap      <= cfg_data[15:0];
        REG_FRAME_GAP:     cfg.frame_gap          <= cfg_data[16:0];
        REG_HEADER:        cfg.header_nibbles     <= cfg_data;
        default:           cfg <= cfg;
      endcase
    end
  end

  xife_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .key_code  (key_code),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  xife_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_space (out_space),
    .pair_push (pair_push),
    .pair      (pair_gen)
  );

  xife_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .pair_push (pair_push),
    .pair_in   (pair_gen),
    .out_space (out_space),
    .empty     (empty),
    .pop       (pop),
    .pair_out  (pair_head)
  );

  assign mark_us  = pair_head.mark_us;
  assign space_us = pair_head.space_us;
  assign last     = pair_head.last;

endmodule

`default_nettype wire

// File: sim/xmp_ir_frame_encoder_test.sv
// Self-checking testbench for the XMP infrared frame encoder: directed table, then random phases.
`timescale 1ns / 1ps

module xmp_ir_frame_encoder_test;
  import xife_pkg::*;

  localparam int PAIRS_PER_FRAME = 36;
  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_PHASES   = 8;
  localparam int KEYS_PER_PHASE  = 20;
  localparam int NPLAN           = 27;
  localparam int NO_PICK         = -1;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_KEY, ROW_CFG} row_kind_t;

  typedef enum logic [1:0] {
    SET_RANDOM,
    SET_ZERO,
    SET_MAX,
    SET_SMALL
  } setting_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] sel;
    logic [CFG_DATA_W-1:0]  data;
    logic [7:0]             key;
    int                     pick;
    logic [16:0]            want_space;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   push      = 1'b0;
  logic [7:0]             key_code  = '0;
  logic                   pop       = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   full;
  logic                   empty;
  logic [9:0]             mark_us;
  logic [16:0]            space_us;
  logic                   last;

  cfg_t      shadow_cfg;
  pair_t     pairs_due [$];
  stim_row_t plan [NPLAN];
  int        mismatches = 0;
  int        stall_left = 0;
  bit        steady     = 1'b0;

  xmp_ir_frame_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .key_code  (key_code),
    .empty     (empty),
    .pop       (pop),
    .mark_us   (mark_us),
    .space_us  (space_us),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [16:0] nibble_space(input logic [3:0] nib);
    int s;
    s = int'(shadow_cfg.nibble_prefix_time) + int'(shadow_cfg.unit_time) * int'(nib);
    return s[16:0];
  endfunction

  function automatic void predict_frame(input logic [7:0] key, input int pick,
                                        input logic [16:0] want);
    logic [3:0] nibs [32];
    logic [3:0] hi;
    logic [3:0] lo;
    pair_t      p;
    int         blk;
    int         pos;
    hi = key[7:4];
    lo = key[3:0];
    for (int k = 0; k < 8; k++) begin
      nibs[k]      = shadow_cfg.header_nibbles[31-4*k -: 4];
      nibs[16 + k] = shadow_cfg.header_nibbles[31-4*k -: 4];
      nibs[8 + k]  = '0;
      nibs[24 + k] = '0;
    end
    nibs[8]  = NIB_BLOCK_START;
    nibs[12] = hi;
    nibs[13] = lo;
    nibs[9]  = 4'd0 - (NIB_BLOCK_START + hi + lo);
    nibs[24] = NIB_BLOCK_START;
    nibs[26] = NIB_B_MARKER;
    nibs[28] = hi;
    nibs[29] = lo;
    nibs[25] = 4'd0 - (NIB_BLOCK_START + NIB_B_MARKER + hi + lo);
    for (int k = 0; k < PAIRS_PER_FRAME; k++) begin
      blk = k / 9;
      pos = k % 9;
      p.mark_us = shadow_cfg.leader_time;
      if (pos < int'(POS_GAP)) begin
        p.space_us = nibble_space(nibs[blk * 8 + pos]);
      end else if (blk == int'(BLK_DATA_A)) begin
        p.space_us = shadow_cfg.frame_gap;
      end else if (blk == int'(BLK_DATA_B)) begin
        p.space_us = '0;
      end else begin
        p.space_us = 17'(shadow_cfg.halfframe_gap);
      end
      if (k == pick) begin
        p.space_us = want;
      end
      p.last = (k == PAIRS_PER_FRAME - 1);
      pairs_due.push_back(p);
    end
  endfunction

  task automatic send_key(input logic [7:0] key, input int pick, input logic [16:0] want);
    push     <= 1'b1;
    key_code <= key;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_frame(key, pick, want);
  endtask

  task automatic hold_off(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_hold_off(input int odds);
    if (!steady && $urandom_range(0, 3) < odds) begin
      hold_off($urandom_range(1, 16));
    end
  endtask

  // Registers change only once every pair already due has been popped.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
    push <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_UNIT_TIME:     shadow_cfg.unit_time          = data[9:0];
      REG_LEADER_TIME:   shadow_cfg.leader_time        = data[9:0];
      REG_PREFIX_TIME:   shadow_cfg.nibble_prefix_time = data[11:0];
      REG_HALFFRAME_GAP: shadow_cfg.halfframe_gap      = data[15:0];
      REG_FRAME_GAP:     shadow_cfg.frame_gap          = data[16:0];
      REG_HEADER:        shadow_cfg.header_nibbles     = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop        <= 1'b0;
    end else if (!steady && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 16) - 1;
      pop        <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pair_t due;
    if (!rst && pop && !empty) begin
      if (pairs_due.size() == 0) begin
        $error("pair popped with none due: mark_us %0d space_us %0d last %0d",
               mark_us, space_us, last);
        mismatches++;
      end else begin
        due = pairs_due.pop_front();
        if (mark_us !== due.mark_us) begin
          $error("mark_us: expected %0d, got %0d", due.mark_us, mark_us);
          mismatches++;
        end
        if (space_us !== due.space_us) begin
          $error("space_us: expected %0d, got %0d", due.space_us, space_us);
          mismatches++;
        end
        if (last !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, last);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("xmp_ir_frame_encoder_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    setting_t              setting;
    logic [CFG_DATA_W-1:0] value;
    int                    gap_odds;

    shadow_cfg.unit_time          = RST_UNIT_TIME;
    shadow_cfg.leader_time        = RST_LEADER_TIME;
    shadow_cfg.nibble_prefix_time = RST_PREFIX_TIME;
    shadow_cfg.halfframe_gap      = RST_HALFFRAME_GAP;
    shadow_cfg.frame_gap          = RST_FRAME_GAP;
    shadow_cfg.header_nibbles     = RST_HEADER;

    // Typed spaces hold under the register values in force at that row.
    plan = '{
      '{ROW_KEY, '0, '0, 8'h00, 0, 17'd895},
      '{ROW_KEY, '0, '0, 8'h00, 10, 17'd2813},
      '{ROW_KEY, '0, '0, 8'h5A, 8, 17'd13560},
      '{ROW_KEY, '0, '0, 8'hA5, 17, 17'd82392},
      '{ROW_KEY, '0, '0, 8'hFF, 35, 17'd0},
      '{ROW_KEY, '0, '0, 8'h0F, NO_PICK, '0},
      '{ROW_KEY, '0, '0, 8'hF0, NO_PICK, '0},
      '{ROW_KEY, '0, '0, 8'hFF, NO_PICK, '0},
      '{ROW_CFG, REG_UNIT_TIME, 32'd0, '0, NO_PICK, '0},
      '{ROW_CFG, REG_PREFIX_TIME, 32'd0, '0, NO_PICK, '0},
      '{ROW_KEY, '0, '0, 8'h37, 13, 17'd0},
      '{ROW_CFG, REG_UNIT_TIME, 32'hFFFFFFFF, '0, NO_PICK, '0},
      '{ROW_CFG, REG_PREFIX_TIME, 32'hFFFFFFFF, '0, NO_PICK, '0},
      '{ROW_CFG, REG_LEADER_TIME, 32'hFFFFFFFF, '0, NO_PICK, '0},
      '{ROW_CFG, REG_HALFFRAME_GAP, 32'hFFFFFFFF, '0, NO_PICK, '0},
      '{ROW_CFG, REG_FRAME_GAP, 32'hFFFFFFFF, '0, NO_PICK, '0},
      '{ROW_CFG, REG_HEADER, 32'hFFFFFFFF, '0, NO_PICK, '0},
      '{ROW_KEY, '0, '0, 8'hFF, 0, 17'd19440},
      '{ROW_KEY, '0, '0, 8'hFF, 26, 17'd65535},
      '{ROW_KEY, '0, '0, 8'h00, 17, 17'd131071},
      '{ROW_CFG, REG_SPARE_LO, 32'd0, '0, NO_PICK, '0},
      '{ROW_CFG, REG_SPARE_HI, 32'd0, '0, NO_PICK, '0},
      '{ROW_KEY, '0, '0, 8'h00, 8, 17'd65535},
      '{ROW_CFG, REG_HEADER, 32'd0, '0, NO_PICK, '0},
      '{ROW_KEY, '0, '0, 8'h00, 0, 17'd4095},
      '{ROW_CFG, REG_LEADER_TIME, 32'd0, '0, NO_PICK, '0},
      '{ROW_KEY, '0, '0, 8'h81, NO_PICK, '0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NPLAN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].sel, plan[i].data);
      end else begin
        maybe_hold_off(1);
        send_key(plan[i].key, plan[i].pick, plan[i].want_space);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        setting = SET_MAX;
      end else if (ph == 1) begin
        setting = SET_ZERO;
      end else begin
        setting = setting_t'($urandom_range(0, 3));
      end
      for (int r = REG_UNIT_TIME; r <= REG_HEADER; r++) begin
        case (setting)
          SET_ZERO:  value = '0;
          SET_MAX:   value = '1;
          SET_SMALL: value = $urandom_range(0, 15);
          default:   value = $urandom();
        endcase
        write_reg(r[CFG_INDEX_W-1:0], value);
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
      end
      // The closing phase runs with both sides flowing freely.
      steady   = (ph == RANDOM_PHASES - 1);
      gap_odds = $urandom_range(0, 3);
      for (int n = 0; n < KEYS_PER_PHASE; n++) begin
        maybe_hold_off(gap_odds);
        send_key(8'($urandom_range(0, 255)), NO_PICK, '0);
      end
    end

    push <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("xmp_ir_frame_encoder_test OK");
    end else begin
      $display("xmp_ir_frame_encoder_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/xife_pkg.sv
rtl/xife_front.sv
rtl/xife_back.sv
rtl/xife_out_fifo.sv
rtl/xmp_ir_frame_encoder.sv
sim/xmp_ir_frame_encoder_test.sv
